// ===== src/ffha_pkg.sv =====
package ffha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_BLOCKS   = 256;

  localparam int MODE_W  = 1;
  localparam int REQ_W   = 13;
  localparam int ID_W    = 16;
  localparam int STAT_W  = 2;
  localparam int BOFF_W  = 12;

  localparam int OFF_W   = $clog2(HEAP_BYTES);
  localparam int CMP_W   = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 2;
  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);

  localparam logic [CMP_W-1:0] HDR_C     = CMP_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0] HEAP_FREE = OFF_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CNT_W:0]   MAX_C     = (CNT_W + 1)'(MAX_BLOCKS);

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADID = 2'd2;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] size;
  } free_ent_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] size;
  } used_ent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    free_ent_t        wdata;
    logic [IDX_W-1:0] raddr;
  } free_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    used_ent_t        wdata;
    logic [IDX_W-1:0] raddr;
  } used_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   new_id;
    logic [BOFF_W-1:0] block_offset;
  } res_t;

endpackage

// ===== src/ffha_ram.sv =====
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ffha_ctrl.sv =====
module ffha_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ffha_pkg::MODE_W-1:0]   req_mode,
  input  logic [ffha_pkg::REQ_W-1:0]    req_bytes,
  input  logic [ffha_pkg::ID_W-1:0]     req_id,
  output logic                          idle,
  output logic                          res_valid,
  input  logic                          res_take,
  output ffha_pkg::res_t                res,
  output ffha_pkg::free_req_t           freq,
  input  ffha_pkg::free_ent_t           frd,
  output ffha_pkg::used_req_t           ureq,
  input  ffha_pkg::used_ent_t           urd
);

  localparam int OFF_W = ffha_pkg::OFF_W;
  localparam int CMP_W = ffha_pkg::CMP_W;
  localparam int IDX_W = ffha_pkg::IDX_W;
  localparam int CNT_W = ffha_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ASCAN, S_USCAN, S_USHDN, S_LSCAN,
    S_SHUP, S_PUSH, S_RSCAN, S_FSHDN, S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0]             ucnt_r, ucnt_nxt;
  logic [ffha_pkg::ID_W-1:0]    idc_r, idc_nxt;
  logic [ffha_pkg::REQ_W-1:0]   bytes_r, bytes_nxt;
  logic [ffha_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic [CNT_W-1:0]             lim_r, lim_nxt;
  logic                         pend_r, pend_nxt;
  logic [IDX_W-1:0]             pidx_r, pidx_nxt;
  logic [OFF_W-1:0]             boff_r, boff_nxt;
  logic [OFF_W-1:0]             bsize_r, bsize_nxt;
  logic [OFF_W-1:0]             moff_r, moff_nxt;
  logic [OFF_W-1:0]             msize_r, msize_nxt;
  logic [IDX_W-1:0]             m_r, m_nxt;
  ffha_pkg::res_t               res_r, res_nxt;

  logic [CNT_W-1:0] idxm1;
  logic [CMP_W-1:0] need;
  logic [CMP_W-1:0] rd_end;
  logic [CMP_W-1:0] m_end;
  logic [OFF_W-1:0] lsize;
  logic [ffha_pkg::ID_W-1:0] idc_inc;
  logic a_hit, u_hit, l_hit, r_hit;

  assign idxm1   = idx_r - CNT_W'(1);
  assign need    = CMP_W'(bytes_r) + ffha_pkg::HDR_C;
  assign rd_end  = CMP_W'(frd.off) + ffha_pkg::HDR_C + CMP_W'(frd.size);
  assign m_end   = CMP_W'(moff_r) + ffha_pkg::HDR_C + CMP_W'(msize_r);
  assign lsize   = OFF_W'(CMP_W'(frd.size) + CMP_W'(bsize_r) + ffha_pkg::HDR_C);
  assign idc_inc = idc_r + 16'd1;

  assign a_hit = pend_r && (CMP_W'(frd.size) >= need);
  assign u_hit = pend_r && (urd.id == id_r);
  assign l_hit = pend_r && (rd_end == CMP_W'(boff_r));
  assign r_hit = pend_r && (pidx_r != m_r) && (CMP_W'(frd.off) == m_end);

  always_comb begin
    state_nxt = state_r;
    fcnt_nxt  = fcnt_r;
    ucnt_nxt  = ucnt_r;
    idc_nxt   = idc_r;
    bytes_nxt = bytes_r;
    id_nxt    = id_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = pidx_r;
    boff_nxt  = boff_r;
    bsize_nxt = bsize_r;
    moff_nxt  = moff_r;
    msize_nxt = msize_r;
    m_nxt     = m_r;
    res_nxt   = res_r;
    freq       = '0;
    freq.raddr = idx_r[IDX_W-1:0];
    ureq       = '0;
    ureq.raddr = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_INIT: begin
        freq.we         = 1'b1;
        freq.waddr      = '0;
        freq.wdata.off  = '0;
        freq.wdata.size = ffha_pkg::HEAP_FREE;
        state_nxt       = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          bytes_nxt = req_bytes;
          id_nxt    = req_id;
          res_nxt   = '0;
          if (req_mode == ffha_pkg::MODE_ALLOC) begin
            if (({1'b0, fcnt_r} + {1'b0, ucnt_r}) >= ffha_pkg::MAX_C) begin
              res_nxt.status = ffha_pkg::ST_NOMEM;
              state_nxt      = S_DONE;
            end else begin
              idx_nxt   = '0;
              state_nxt = S_ASCAN;
            end
          end else begin
            idx_nxt   = ucnt_r;
            state_nxt = S_USCAN;
          end
        end
      end
      S_ASCAN: begin
        if (a_hit) begin
          freq.we         = 1'b1;
          freq.waddr      = pidx_r;
          freq.wdata.off  = OFF_W'(CMP_W'(frd.off) + need);
          freq.wdata.size = OFF_W'(CMP_W'(frd.size) - need);
          ureq.we         = 1'b1;
          ureq.waddr      = ucnt_r[IDX_W-1:0];
          ureq.wdata.id   = idc_inc;
          ureq.wdata.off  = frd.off;
          ureq.wdata.size = OFF_W'(bytes_r);
          ucnt_nxt        = ucnt_r + CNT_W'(1);
          idc_nxt         = idc_inc;
          res_nxt.status       = ffha_pkg::ST_OK;
          res_nxt.new_id       = idc_inc;
          res_nxt.block_offset = ffha_pkg::BOFF_W'(frd.off);
          state_nxt            = S_DONE;
        end else if (idx_r != fcnt_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end else begin
          res_nxt.status = ffha_pkg::ST_NOMEM;
          state_nxt      = S_DONE;
        end
      end
      S_USCAN: begin
        ureq.raddr = idxm1[IDX_W-1:0];
        if (u_hit) begin
          boff_nxt  = urd.off;
          bsize_nxt = urd.size;
          idx_nxt   = CNT_W'(pidx_r) + CNT_W'(1);
          lim_nxt   = ucnt_r;
          state_nxt = S_USHDN;
        end else if (idx_r != '0) begin
          pend_nxt = 1'b1;
          pidx_nxt = idxm1[IDX_W-1:0];
          idx_nxt  = idxm1;
        end else begin
          res_nxt.status = ffha_pkg::ST_BADID;
          state_nxt      = S_DONE;
        end
      end
      S_USHDN: begin
        if (pend_r) begin
          ureq.we    = 1'b1;
          ureq.waddr = pidx_r - IDX_W'(1);
          ureq.wdata = urd;
        end
        if (idx_r != lim_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end else if (!pend_r) begin
          ucnt_nxt  = ucnt_r - CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = S_LSCAN;
        end
      end
      S_LSCAN: begin
        if (l_hit) begin
          freq.we         = 1'b1;
          freq.waddr      = pidx_r;
          freq.wdata.off  = frd.off;
          freq.wdata.size = lsize;
          m_nxt           = pidx_r;
          moff_nxt        = frd.off;
          msize_nxt       = lsize;
          idx_nxt         = '0;
          state_nxt       = S_RSCAN;
        end else if (idx_r != fcnt_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end else begin
          m_nxt     = '0;
          moff_nxt  = boff_r;
          msize_nxt = bsize_r;
          idx_nxt   = fcnt_r;
          state_nxt = S_SHUP;
        end
      end
      S_SHUP: begin
        freq.raddr = idxm1[IDX_W-1:0];
        if (pend_r) begin
          freq.we    = 1'b1;
          freq.waddr = pidx_r + IDX_W'(1);
          freq.wdata = frd;
        end
        if (idx_r != '0) begin
          pend_nxt = 1'b1;
          pidx_nxt = idxm1[IDX_W-1:0];
          idx_nxt  = idxm1;
        end else if (!pend_r) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        freq.we         = 1'b1;
        freq.waddr      = '0;
        freq.wdata.off  = boff_r;
        freq.wdata.size = bsize_r;
        fcnt_nxt        = fcnt_r + CNT_W'(1);
        idx_nxt         = '0;
        state_nxt       = S_RSCAN;
      end
      S_RSCAN: begin
        if (r_hit) begin
          freq.we         = 1'b1;
          freq.waddr      = m_r;
          freq.wdata.off  = moff_r;
          freq.wdata.size = OFF_W'(CMP_W'(msize_r) + CMP_W'(frd.size) + ffha_pkg::HDR_C);
          idx_nxt         = CNT_W'(pidx_r) + CNT_W'(1);
          lim_nxt         = fcnt_r;
          state_nxt       = S_FSHDN;
        end else if (idx_r != fcnt_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end else begin
          res_nxt.status = ffha_pkg::ST_OK;
          state_nxt      = S_DONE;
        end
      end
      S_FSHDN: begin
        if (pend_r) begin
          freq.we    = 1'b1;
          freq.waddr = pidx_r - IDX_W'(1);
          freq.wdata = frd;
        end
        if (idx_r != lim_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end else if (!pend_r) begin
          fcnt_nxt       = fcnt_r - CNT_W'(1);
          res_nxt.status = ffha_pkg::ST_OK;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      fcnt_r  <= CNT_W'(1);
      ucnt_r  <= '0;
      idc_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fcnt_r  <= fcnt_nxt;
      ucnt_r  <= ucnt_nxt;
      idc_r   <= idc_nxt;
      pend_r  <= pend_nxt;
    end
    bytes_r <= bytes_nxt;
    id_r    <= id_nxt;
    idx_r   <= idx_nxt;
    lim_r   <= lim_nxt;
    pidx_r  <= pidx_nxt;
    boff_r  <= boff_nxt;
    bsize_r <= bsize_nxt;
    moff_r  <= moff_nxt;
    msize_r <= msize_nxt;
    m_r     <= m_nxt;
    res_r   <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_tables_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fcnt_r} + {1'b0, ucnt_r}) <= ffha_pkg::MAX_C)
    else $error("free and used tables exceed capacity");

  a_free_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r != '0)
    else $error("free table empty");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> ($stable(res_r) && res_valid))
    else $error("result changed while waiting");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> idle)
    else $error("word started while busy");
`endif

endmodule

// ===== src/first_fit_heap_allocator.sv =====
// First-fit heap allocator. mode 0 allocates request_bytes of payload plus a
// header from the first free block large enough and returns a new id and the
// block offset; mode 1 releases the newest allocation with block_id and
// coalesces it with adjacent free blocks. Each word gives exactly one result.
// The free and used tables live in two single-port-read RAMs and the scans walk
// them one entry per cycle. After reset the block seeds the free table in its
// S_INIT state before it takes its first word.
module first_fit_heap_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ffha_pkg::MODE_W-1:0]       in_mode,
  input  logic [ffha_pkg::REQ_W-1:0]        in_request_bytes,
  input  logic [ffha_pkg::ID_W-1:0]         in_block_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ffha_pkg::STAT_W-1:0]       out_status,
  output logic [ffha_pkg::ID_W-1:0]         out_new_id,
  output logic [ffha_pkg::BOFF_W-1:0]       out_block_offset
);

  ffha_pkg::free_req_t freq;
  ffha_pkg::free_ent_t frd;
  ffha_pkg::used_req_t ureq;
  ffha_pkg::used_ent_t urd;
  ffha_pkg::res_t      res;
  ffha_pkg::res_t      out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                idle, res_valid, res_take, start;

  assign start    = in_valid && idle;
  assign in_stall = !idle;
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_mode  (in_mode),
    .req_bytes (in_request_bytes),
    .req_id    (in_block_id),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .freq      (freq),
    .frd       (frd),
    .ureq      (ureq),
    .urd       (urd)
  );

  ffha_ram #(
    .WIDTH ($bits(ffha_pkg::free_ent_t)),
    .DEPTH (ffha_pkg::MAX_BLOCKS)
  ) u_free_ram (
    .clk   (clk),
    .we    (freq.we),
    .waddr (freq.waddr),
    .wdata (freq.wdata),
    .raddr (freq.raddr),
    .rdata (frd)
  );

  ffha_ram #(
    .WIDTH ($bits(ffha_pkg::used_ent_t)),
    .DEPTH (ffha_pkg::MAX_BLOCKS)
  ) u_used_ram (
    .clk   (clk),
    .we    (ureq.we),
    .waddr (ureq.waddr),
    .wdata (ureq.wdata),
    .raddr (ureq.raddr),
    .rdata (urd)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_new_id       = out_r.new_id;
  assign out_block_offset = out_r.block_offset;

endmodule

// ===== bench/first_fit_heap_allocator_tb.sv =====
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 1100;

  class alloc_scoreboard;
    int    fr_off[MAX_BLOCKS];
    int    fr_size[MAX_BLOCKS];
    int    fr_n;
    int    us_id[MAX_BLOCKS];
    int    us_off[MAX_BLOCKS];
    int    us_size[MAX_BLOCKS];
    int    us_n;
    int    id_ctr;
    res_t  expected_q[$];
    int    fails;

    function new();
      fr_off[0]  = 0;
      fr_size[0] = HEAP_BYTES - HEADER_BYTES;
      fr_n       = 1;
      us_n       = 0;
      id_ctr     = 0;
      fails      = 0;
    endfunction

    function void drop_free(int i);
      for (int j = i; j < fr_n - 1; j++) begin
        fr_off[j]  = fr_off[j+1];
        fr_size[j] = fr_size[j+1];
      end
      fr_n--;
    endfunction

    function res_t allocate(int bytes);
      res_t r;
      int   need;
      int   i;
      r    = '0;
      need = bytes + HEADER_BYTES;
      r.status = ST_NOMEM;
      if (fr_n + us_n >= MAX_BLOCKS) return r;
      for (i = 0; i < fr_n; i++)
        if (fr_size[i] >= need) break;
      if (i == fr_n) return r;
      id_ctr = (id_ctr + 1) & 16'hFFFF;
      us_id[us_n]   = id_ctr;
      us_off[us_n]  = fr_off[i];
      us_size[us_n] = bytes;
      us_n++;
      r.status       = ST_OK;
      r.new_id       = ID_W'(id_ctr);
      r.block_offset = BOFF_W'(fr_off[i]);
      fr_off[i]  += need;
      fr_size[i] -= need;
      return r;
    endfunction

    function res_t release_id(int id);
      res_t r;
      int   k;
      int   off;
      int   size;
      int   m;
      int   tail;
      r = '0;
      for (k = us_n - 1; k >= 0; k--)
        if (us_id[k] == id) break;
      if (k < 0) begin
        r.status = ST_BADID;
        return r;
      end
      off  = us_off[k];
      size = us_size[k];
      for (int j = k; j < us_n - 1; j++) begin
        us_id[j]   = us_id[j+1];
        us_off[j]  = us_off[j+1];
        us_size[j] = us_size[j+1];
      end
      us_n--;
      for (int j = fr_n; j > 0; j--) begin
        fr_off[j]  = fr_off[j-1];
        fr_size[j] = fr_size[j-1];
      end
      fr_off[0]  = off;
      fr_size[0] = size;
      fr_n++;
      m = 0;
      for (int i = 1; i < fr_n; i++) begin
        if (fr_off[i] + HEADER_BYTES + fr_size[i] == off) begin
          fr_size[i] += size + HEADER_BYTES;
          drop_free(0);
          m = i - 1;
          break;
        end
      end
      tail = fr_off[m] + HEADER_BYTES + fr_size[m];
      for (int i = 0; i < fr_n; i++) begin
        if (i != m && fr_off[i] == tail) begin
          fr_size[m] += fr_size[i] + HEADER_BYTES;
          drop_free(i);
          break;
        end
      end
      r.status = ST_OK;
      return r;
    endfunction

    function res_t note_word(logic [MODE_W-1:0] mode, int bytes, int id);
      res_t r;
      if (mode == MODE_ALLOC) r = allocate(bytes);
      else r = release_id(id);
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: status %0d id %0d offset %0d",
                   got.status, got.new_id, got.block_offset);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status != exp_r.status || got.new_id != exp_r.new_id ||
          got.block_offset != exp_r.block_offset) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected status %0d id %0d offset %0d, got %0d %0d %0d",
                   exp_r.status, exp_r.new_id, exp_r.block_offset,
                   got.status, got.new_id, got.block_offset);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [REQ_W-1:0]    in_request_bytes;
  logic [ID_W-1:0]     in_block_id;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [ID_W-1:0]     out_new_id;
  logic [BOFF_W-1:0]   out_block_offset;

  alloc_scoreboard sb;
  int              src_idle_pct;
  int              snk_idle_pct;
  int              quiet_cycles = 0;
  int              live_ids[$];

  first_fit_heap_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_request_bytes (in_request_bytes),
    .in_block_id      (in_block_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_new_id       (out_new_id),
    .out_block_offset (out_block_offset)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_status, out_new_id, out_block_offset});
    out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("first_fit_heap_allocator_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_word(logic [MODE_W-1:0] mode, int bytes, int id);
    res_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_request_bytes <= REQ_W'(bytes);
    in_block_id      <= ID_W'(id);
    do @(posedge clk); while (in_stall);
    r = sb.note_word(mode, bytes, id);
    if (mode == MODE_ALLOC && r.status == ST_OK) begin
      live_ids.push_back(r.new_id);
    end else if (mode == MODE_FREE && r.status == ST_OK) begin
      for (int i = live_ids.size() - 1; i >= 0; i--)
        if (live_ids[i] == id) begin
          live_ids.delete(i);
          break;
        end
    end
  endtask

  task automatic send_alloc(int bytes);
    send_word(MODE_ALLOC, bytes, $urandom_range(0, 65535));
  endtask

  task automatic send_free(int id);
    send_word(MODE_FREE, $urandom_range(0, 8191), id);
  endtask

  task automatic free_live_at(int idx);
    send_free(live_ids[idx]);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = MODE_ALLOC;
    in_request_bytes = '0;
    in_block_id      = '0;
    src_idle_pct     = 29;
    snk_idle_pct     = 45;
    sb               = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_alloc(0);
    send_alloc(8191);
    send_alloc(4096);
    send_alloc(HEAP_BYTES - 3 * HEADER_BYTES);
    send_alloc(0);
    send_free(2);
    send_free(1);
    send_free(16'hFFFF);
    send_free(0);
    send_alloc(100);
    send_alloc(200);
    send_alloc(300);
    send_alloc(4000);
    send_free(4);
    send_free(3);
    send_free(5);
    send_free(5);
    send_free(16'h5555);
    send_free(16'hAAAA);

    // fill the tables with header-only blocks until capacity runs out
    repeat (258) send_alloc(0);
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);

    src_idle_pct = 45;
    snk_idle_pct = 29;
    for (int n = 0; n < 130; n++) begin
      if (n == 65) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < 55) begin
        case ($urandom_range(0, 9))
          0:       send_alloc($urandom_range(0, 4096));
          1:       send_alloc($urandom_range(0, 8191));
          default: send_alloc($urandom_range(0, 300));
        endcase
      end else if (live_ids.size() > 0 && $urandom_range(0, 99) < 80) begin
        free_live_at($urandom_range(0, live_ids.size() - 1));
      end else begin
        send_free($urandom_range(0, 65535));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("first_fit_heap_allocator_tb OK");
    else
      $display("first_fit_heap_allocator_tb NOT OK");
    $finish;
  end

endmodule
